// ===== rtl/core/scl_pkg.sv =====
// Shared types and constants for the sequence code lock.
// Used by the controller, the datapath and the top level; depends on nothing.
package scl_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int CODE_SYMBOLS    = 16;

    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int CODE_LEN_W      = 5;
    localparam int HOLD_W          = 16;
    localparam int SINCE_W         = 17;
    localparam int KEY_W           = 3;
    localparam int COUNT_W         = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SYMBOLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 2'd2;

    localparam logic                 KIND_TICK = 1'b0;
    localparam logic                 KIND_KEY  = 1'b1;
    localparam logic [KEY_W-1:0]     KEY_RIGHT = 3'd3;
    localparam logic [KEY_W-1:0]     KEY_ENTER = 3'd4;

    localparam logic [SINCE_W-1:0]   SINCE_MAX  = 17'h1FFFF;
    localparam logic [HOLD_W-1:0]    HOLD_RESET = 16'd2000;

    typedef struct packed {
        logic step;
        logic cmp_start;
        logic cmp_next;
        logic finish_match;
        logic finish_wrong;
    } t_dp_cmd;

    typedef struct packed {
        logic enter_ok;
        logic is_open;
        logic len_match;
        logic total_zero;
        logic sym_eq;
        logic idx_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/core/scl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scl_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/scl_ctrl.sv =====
// Controller state machine: accepts items and sequences the serial code compare.
// Depends on scl_pkg for command and status types.
module scl_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_kind,
    input  logic [scl_pkg::KEY_W-1:0] i_key,
    input  scl_pkg::t_dp_status       i_status,
    output scl_pkg::t_dp_cmd          o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic             w_accept;
    logic             w_lock_enter;
    scl_pkg::t_dp_cmd w_cmd;

    assign o_in_ready   = (r_state == S_IDLE) && i_status.out_free;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_lock_enter = (i_kind == scl_pkg::KIND_KEY) && (i_key == scl_pkg::KEY_ENTER)
                          && i_status.enter_ok && !i_status.is_open;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!w_lock_enter) begin
                        w_cmd.step = 1'b1;
                    end else if (!i_status.len_match) begin
                        w_cmd.finish_wrong = 1'b1;
                    end else if (i_status.total_zero) begin
                        w_cmd.finish_match = 1'b1;
                    end else begin
                        w_cmd.cmp_start = 1'b1;
                        n_state         = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_status.sym_eq) begin
                    w_cmd.finish_wrong = 1'b1;
                    n_state            = S_IDLE;
                end else if (i_status.idx_last) begin
                    w_cmd.finish_match = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    w_cmd.cmp_next = 1'b1;
                    n_state        = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = w_cmd;

endmodule

// ===== rtl/core/scl_dp.sv =====
// Datapath: configuration registers, lock state, tick counter, entry RAM and result register.
// Depends on scl_pkg and scl_ram.
module scl_dp #(
    parameter int MAX_ENTRIES = scl_pkg::MAX_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [scl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_kind,
    input  logic [scl_pkg::KEY_W-1:0]      i_key,
    input  scl_pkg::t_dp_cmd               i_cmd,
    output scl_pkg::t_dp_status            o_status,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_unlocked,
    output logic [scl_pkg::COUNT_W-1:0]    o_entry_count,
    output logic                           o_wrong_code,
    output logic                           o_enter_ignored
);

    localparam int TW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = (TW > scl_pkg::CODE_LEN_W) ? TW : scl_pkg::CODE_LEN_W;

    logic [scl_pkg::CFG_DATA_W-1:0] r_code_symbols;
    logic [scl_pkg::CODE_LEN_W-1:0] r_code_length;
    logic [scl_pkg::HOLD_W-1:0]     r_hold_ticks;

    logic [TW-1:0]                  r_total;
    logic [TW-1:0]                  n_total;
    logic                           r_open;
    logic                           n_open;
    logic [scl_pkg::SINCE_W-1:0]    r_since;
    logic [scl_pkg::SINCE_W-1:0]    n_since;
    logic [IW-1:0]                  r_idx;

    logic                           r_out_valid;
    logic                           r_unlocked;
    logic [scl_pkg::COUNT_W-1:0]    r_entry_count;
    logic                           r_wrong_code;
    logic                           r_enter_ignored;

    logic                           w_load;
    logic                           w_wrong;
    logic                           w_ignored;
    logic                           w_we;
    logic [1:0]                     w_rdata;
    logic [scl_pkg::CFG_DATA_W-1:0] w_code_shift;
    logic [1:0]                     w_want;
    logic                           w_enter_ok;

    assign w_enter_ok   = r_since > {1'b0, r_hold_ticks};
    assign w_code_shift = r_code_symbols >> {r_idx, 1'b0};
    assign w_want       = (6'(r_idx) < 6'(scl_pkg::CODE_SYMBOLS)) ? w_code_shift[1:0] : 2'd0;

    assign w_we = i_cmd.step && (i_kind == scl_pkg::KIND_KEY)
                  && (i_key <= scl_pkg::KEY_RIGHT) && (r_total < TW'(MAX_ENTRIES));

    scl_ram #(
        .WIDTH (2),
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_total[IW-1:0]),
        .i_wdata (i_key[1:0]),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_total   = r_total;
        n_open    = r_open;
        n_since   = r_since;
        w_wrong   = 1'b0;
        w_ignored = 1'b0;
        if (i_cmd.step) begin
            if (i_kind == scl_pkg::KIND_TICK) begin
                if (r_since != scl_pkg::SINCE_MAX) begin
                    n_since = r_since + 1'b1;
                end
            end else if (i_key <= scl_pkg::KEY_RIGHT) begin
                if (w_we) begin
                    n_total = r_total + 1'b1;
                end
            end else if (i_key == scl_pkg::KEY_ENTER) begin
                if (w_enter_ok) begin
                    n_open  = 1'b0;
                    n_since = scl_pkg::SINCE_MAX;
                end else begin
                    w_ignored = 1'b1;
                end
            end
        end else if (i_cmd.finish_match) begin
            n_open  = 1'b1;
            n_since = '0;
            n_total = '0;
        end else if (i_cmd.finish_wrong) begin
            w_wrong = 1'b1;
            n_total = '0;
        end
    end

    assign w_load = i_cmd.step || i_cmd.finish_match || i_cmd.finish_wrong;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_symbols <= '0;
            r_code_length  <= '0;
            r_hold_ticks   <= scl_pkg::HOLD_RESET;
            r_total        <= '0;
            r_open         <= 1'b0;
            r_since        <= '0;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    scl_pkg::CFG_CODE_SYMBOLS: r_code_symbols <= i_cfg_data;
                    scl_pkg::CFG_CODE_LENGTH:  r_code_length  <= i_cfg_data[scl_pkg::CODE_LEN_W-1:0];
                    scl_pkg::CFG_HOLD_TICKS:   r_hold_ticks   <= i_cfg_data[scl_pkg::HOLD_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_total <= n_total;
            r_open  <= n_open;
            r_since <= n_since;
            if (i_cmd.cmp_start) begin
                r_idx <= '0;
            end else if (i_cmd.cmp_next) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_unlocked      <= n_open;
            r_entry_count   <= scl_pkg::COUNT_W'(n_total);
            r_wrong_code    <= w_wrong;
            r_enter_ignored <= w_ignored;
        end
    end

    assign o_status.enter_ok   = w_enter_ok;
    assign o_status.is_open    = r_open;
    assign o_status.len_match  = CW'(r_total) == CW'(r_code_length);
    assign o_status.total_zero = r_total == '0;
    assign o_status.sym_eq     = w_rdata == w_want;
    assign o_status.idx_last   = (CW'(r_idx) + CW'(1)) == CW'(r_total);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_unlocked      = r_unlocked;
    assign o_entry_count   = r_entry_count;
    assign o_wrong_code    = r_wrong_code;
    assign o_enter_ignored = r_enter_ignored;

endmodule

// ===== rtl/core/sequence_code_lock_top.sv =====
// Top level of the sequence code lock: streaming ports, configuration port,
// controller and datapath. Depends on scl_pkg, scl_ctrl and scl_dp.
//
// Ticks, direction keys, other keys, ignored enters and a relocking enter each
// produce their result in the cycle after the transfer. An accepted enter while
// locked, with the entry count equal to code_length and N > 0 symbols held,
// compares the entries one at a time through the registered read port of the
// entry RAM, alternating read and check states, and ends at the first mismatch
// or the last entry. One item is processed at a time; a finished result sits
// in an output register, and the next item is taken once that register is
// empty or being read in the same cycle. Configuration writes are always accepted.
module sequence_code_lock_top #(
    parameter int MAX_ENTRIES = scl_pkg::MAX_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [2:0] key, [7:3] zero
    input  logic                           s_axis_tuser,   // [0] kind
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [0] unlocked, [5:1] entry_count,
                                                           // [6] wrong_code, [7] enter_ignored
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [scl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    scl_pkg::t_dp_cmd               w_cmd;
    scl_pkg::t_dp_status            w_status;
    logic [scl_pkg::KEY_W-1:0]      w_key;
    logic                           w_unlocked;
    logic [scl_pkg::COUNT_W-1:0]    w_entry_count;
    logic                           w_wrong_code;
    logic                           w_enter_ignored;

    assign w_key       = s_axis_tdata[scl_pkg::KEY_W-1:0];
    assign o_cfg_ready = 1'b1;

    scl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_kind     (s_axis_tuser),
        .i_key      (w_key),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    scl_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (s_axis_tuser),
        .i_key           (w_key),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_unlocked      (w_unlocked),
        .o_entry_count   (w_entry_count),
        .o_wrong_code    (w_wrong_code),
        .o_enter_ignored (w_enter_ignored)
    );

    assign m_axis_tdata = {w_enter_ignored, w_wrong_code, w_entry_count, w_unlocked};

endmodule
